>>> rtl/core/ffha_pkg.sv
// Shared types, widths and command codes of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

	localparam int OFF_W     = 17;
	localparam int GSZ_W     = 14;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 8'd1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_SPACE   = 2'd1;
	localparam logic [1:0] ST_BAD_FREE   = 2'd2;
	localparam logic [1:0] ST_TABLE_FULL = 2'd3;

	localparam logic OPC_ALLOC = 1'b0;
	localparam logic OPC_FREE  = 1'b1;

	// datapath commands
	localparam logic [4:0] OP_NOP        = 5'd0;
	localparam logic [4:0] OP_INIT       = 5'd1;
	localparam logic [4:0] OP_CLEAR      = 5'd2;
	localparam logic [4:0] OP_CAPTURE    = 5'd3;
	localparam logic [4:0] OP_FT_READ    = 5'd4;
	localparam logic [4:0] OP_IDX_INC    = 5'd5;
	localparam logic [4:0] OP_SCAN_NEXT  = 5'd6;
	localparam logic [4:0] OP_GR_READ    = 5'd7;
	localparam logic [4:0] OP_SPLIT      = 5'd8;
	localparam logic [4:0] OP_TAKE       = 5'd9;
	localparam logic [4:0] OP_SD_READ    = 5'd10;
	localparam logic [4:0] OP_SD_WRITE   = 5'd11;
	localparam logic [4:0] OP_CNT_DEC    = 5'd12;
	localparam logic [4:0] OP_MERGE_BOTH = 5'd13;
	localparam logic [4:0] OP_MERGE_PREV = 5'd14;
	localparam logic [4:0] OP_MERGE_NEXT = 5'd15;
	localparam logic [4:0] OP_SU_INIT    = 5'd16;
	localparam logic [4:0] OP_SU_READ    = 5'd17;
	localparam logic [4:0] OP_SU_WRITE   = 5'd18;
	localparam logic [4:0] OP_INSERT     = 5'd19;
	localparam logic [4:0] OP_ALLOC_FIN  = 5'd20;
	localparam logic [4:0] OP_FREE_FIN   = 5'd21;
	localparam logic [4:0] OP_RESULT     = 5'd22;

	typedef struct packed {
		logic        op;
		logic [15:0] request_bytes;
		logic [31:0] release_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] payload_address;
		logic [1:0]  status;
		logic [16:0] free_byte_count;
	} out_item_t;

	typedef struct packed {
		logic [OFF_W-1:0] start;
		logic [OFF_W-1:0] len;
	} ft_entry_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] res;
	} cmd_t;

	typedef struct packed {
		logic idx_lt_cnt;
		logic fit;
		logic split_ok;
		logic start_lt_off;
		logic gran_zero;
		logic join_prev;
		logic join_next;
		logic full;
		logic k_gt_idx;
		logic k1_lt_cnt;
		logic is_free;
		logic null_free;
		logic range_bad;
		logic clr_done;
		logic reinit;
	} stat_t;

endpackage

>>> rtl/core/ffha_ctrl.sv
// Sequencer of the allocator: steps the datapath through each operation.
`timescale 1ns / 1ps
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  ffha_pkg::stat_t stat,
	output ffha_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_INIT    = 5'd0;
	localparam logic [4:0] S_CLEAR   = 5'd1;
	localparam logic [4:0] S_IDLE    = 5'd2;
	localparam logic [4:0] S_DISP    = 5'd3;
	localparam logic [4:0] S_A_RD    = 5'd4;
	localparam logic [4:0] S_A_CHK   = 5'd5;
	localparam logic [4:0] S_SD_CHK  = 5'd6;
	localparam logic [4:0] S_SD_WR   = 5'd7;
	localparam logic [4:0] S_A_FIN   = 5'd8;
	localparam logic [4:0] S_F_GR    = 5'd9;
	localparam logic [4:0] S_F_GCHK  = 5'd10;
	localparam logic [4:0] S_F_RD    = 5'd11;
	localparam logic [4:0] S_F_CHK   = 5'd12;
	localparam logic [4:0] S_F_DEC   = 5'd13;
	localparam logic [4:0] S_SU_CHK  = 5'd14;
	localparam logic [4:0] S_SU_WR   = 5'd15;
	localparam logic [4:0] S_F_FIN   = 5'd16;
	localparam logic [4:0] S_RES     = 5'd17;

	logic [4:0] state_q, state_d;
	logic [1:0] res_q, res_d;
	logic       out_valid_q, out_valid_d;
	logic       fin;
	logic       slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		fin     = 1'b0;
		cmd.op  = ffha_pkg::OP_NOP;
		cmd.res = res_q;
		unique case (state_q)
			S_INIT: begin
				cmd.op  = ffha_pkg::OP_INIT;
				state_d = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.op = ffha_pkg::OP_CLEAR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ffha_pkg::OP_CAPTURE;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				if (!stat.is_free) begin
					state_d = S_A_RD;
				end else if (stat.null_free) begin
					res_d   = ffha_pkg::ST_OK;
					state_d = S_RES;
				end else if (stat.range_bad) begin
					res_d   = ffha_pkg::ST_BAD_FREE;
					state_d = S_RES;
				end else begin
					state_d = S_F_GR;
				end
			end
			S_A_RD: begin
				if (stat.idx_lt_cnt) begin
					cmd.op  = ffha_pkg::OP_FT_READ;
					state_d = S_A_CHK;
				end else begin
					res_d   = ffha_pkg::ST_NO_SPACE;
					state_d = S_RES;
				end
			end
			S_A_CHK: begin
				if (!stat.fit) begin
					cmd.op  = ffha_pkg::OP_IDX_INC;
					state_d = S_A_RD;
				end else if (stat.split_ok) begin
					cmd.op  = ffha_pkg::OP_SPLIT;
					state_d = S_A_FIN;
				end else begin
					cmd.op  = ffha_pkg::OP_TAKE;
					state_d = S_SD_CHK;
				end
			end
			S_SD_CHK: begin
				if (stat.k1_lt_cnt) begin
					cmd.op  = ffha_pkg::OP_SD_READ;
					state_d = S_SD_WR;
				end else begin
					cmd.op  = ffha_pkg::OP_CNT_DEC;
					state_d = stat.is_free ? S_F_FIN : S_A_FIN;
				end
			end
			S_SD_WR: begin
				cmd.op  = ffha_pkg::OP_SD_WRITE;
				state_d = S_SD_CHK;
			end
			S_A_FIN: begin
				if (slot_free) begin
					cmd.op  = ffha_pkg::OP_ALLOC_FIN;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_F_GR: begin
				cmd.op  = ffha_pkg::OP_GR_READ;
				state_d = S_F_GCHK;
			end
			S_F_GCHK: begin
				if (stat.gran_zero) begin
					res_d   = ffha_pkg::ST_BAD_FREE;
					state_d = S_RES;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_RD: begin
				if (stat.idx_lt_cnt) begin
					cmd.op  = ffha_pkg::OP_FT_READ;
					state_d = S_F_CHK;
				end else begin
					state_d = S_F_DEC;
				end
			end
			S_F_CHK: begin
				if (stat.start_lt_off) begin
					cmd.op  = ffha_pkg::OP_SCAN_NEXT;
					state_d = S_F_RD;
				end else begin
					state_d = S_F_DEC;
				end
			end
			S_F_DEC: begin
				if (stat.join_prev && stat.join_next) begin
					cmd.op  = ffha_pkg::OP_MERGE_BOTH;
					state_d = S_SD_CHK;
				end else if (stat.join_prev) begin
					cmd.op  = ffha_pkg::OP_MERGE_PREV;
					state_d = S_F_FIN;
				end else if (stat.join_next) begin
					cmd.op  = ffha_pkg::OP_MERGE_NEXT;
					state_d = S_F_FIN;
				end else if (stat.full) begin
					res_d   = ffha_pkg::ST_TABLE_FULL;
					state_d = S_RES;
				end else begin
					cmd.op  = ffha_pkg::OP_SU_INIT;
					state_d = S_SU_CHK;
				end
			end
			S_SU_CHK: begin
				if (stat.k_gt_idx) begin
					cmd.op  = ffha_pkg::OP_SU_READ;
					state_d = S_SU_WR;
				end else begin
					cmd.op  = ffha_pkg::OP_INSERT;
					state_d = S_F_FIN;
				end
			end
			S_SU_WR: begin
				cmd.op  = ffha_pkg::OP_SU_WRITE;
				state_d = S_SU_CHK;
			end
			S_F_FIN: begin
				if (slot_free) begin
					cmd.op  = ffha_pkg::OP_FREE_FIN;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RES: begin
				if (slot_free) begin
					cmd.op  = ffha_pkg::OP_RESULT;
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
		// a heap_bytes write restarts the heap
		if (stat.reinit) state_d = S_INIT;
	end

	always_comb begin
		if (fin) out_valid_d = 1'b1;
		else if (!out_stall) out_valid_d = 1'b0;
		else out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			res_q       <= ffha_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_q       <= res_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

>>> rtl/core/ffha_datapath.sv
// Datapath of the allocator: free table, block size memory, counters, result register.
`timescale 1ns / 1ps
module ffha_datapath #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int FREE_SLOTS     = 16,
	parameter int HEADER_BYTES   = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ffha_pkg::cmd_t                     cmd,
	output ffha_pkg::stat_t                    stat,
	input  ffha_pkg::in_item_t                 in_data,
	input  logic                               cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                        cfg_data,
	output ffha_pkg::out_item_t                out_data
);

	localparam int HDR       = (HEADER_BYTES + 7) / 8 * 8;
	localparam int GRANULES  = HEAP_MAX_BYTES / 8;
	localparam int GR_DEPTH  = (GRANULES < 16384) ? GRANULES : 16384;
	localparam int GI_W      = $clog2(GR_DEPTH);
	localparam int FI_W      = $clog2(FREE_SLOTS);
	localparam int CNT_W     = $clog2(FREE_SLOTS + 1);
	localparam int OW        = ffha_pkg::OFF_W;
	localparam logic [OW-1:0] HDR_L     = OW'(HDR);
	localparam logic [OW-1:0] SPLIT_MIN = OW'(HDR + 8);

	// configuration
	logic [31:0]   base_hdr_q;
	logic [16:0]   hb_q;

	// control state
	logic [OW-1:0]    usable_q, remaining_q;
	logic [CNT_W-1:0] count_q, idx_q, k_q;
	logic [GI_W-1:0]  clr_q;

	// per-transaction payload
	logic                     op_q, null_q, rbad_q;
	logic [OW-1:0]            need_q, off_q, size_q, blk_q;
	ffha_pkg::ft_entry_t      rd_q, prev_q;
	logic [ffha_pkg::GSZ_W-1:0] grd_q;
	ffha_pkg::out_item_t      out_q;

	// memories
	ffha_pkg::ft_entry_t        ft_mem [FREE_SLOTS];
	logic [ffha_pkg::GSZ_W-1:0] gr_mem [GR_DEPTH];

	logic [31:0]      eff, off32;
	logic [OW-1:0]    usable_c, need_c, size_f;
	logic [CNT_W-1:0] idx_m1, k_p1, k_m1;
	logic             ft_we, ft_re, gr_we, gr_re;
	logic [FI_W-1:0]  ft_wa, ft_ra;
	ffha_pkg::ft_entry_t ft_wd;
	logic [GI_W-1:0]  gr_wa, gr_ra;
	logic [ffha_pkg::GSZ_W-1:0] gr_wd;

	always_comb begin
		eff = ({15'b0, hb_q} > 32'(HEAP_MAX_BYTES)) ? 32'(HEAP_MAX_BYTES) : {15'b0, hb_q};
		eff = eff & ~32'd7;
		if (eff < 32'd64) eff = 32'd64;
		usable_c = (eff > 32'(HDR)) ? OW'(eff - 32'(HDR)) : '0;
	end

	assign need_c = (OW'(in_data.request_bytes) + HDR_L + OW'(7)) & ~OW'(7);
	assign off32  = in_data.release_address - base_hdr_q;
	assign size_f = {grd_q, 3'b000};
	assign idx_m1 = idx_q - CNT_W'(1);
	assign k_p1   = k_q + CNT_W'(1);
	assign k_m1   = k_q - CNT_W'(1);

	always_comb begin
		stat.idx_lt_cnt   = idx_q < count_q;
		stat.fit          = rd_q.len >= need_q;
		stat.split_ok     = (rd_q.len - need_q) >= SPLIT_MIN;
		stat.start_lt_off = rd_q.start < off_q;
		stat.gran_zero    = (grd_q == '0);
		stat.join_prev    = (idx_q != '0) && ((prev_q.start + prev_q.len) == off_q);
		stat.join_next    = (idx_q < count_q) && ((off_q + size_f) == rd_q.start);
		stat.full         = count_q >= CNT_W'(FREE_SLOTS);
		stat.k_gt_idx     = k_q > idx_q;
		stat.k1_lt_cnt    = ({1'b0, k_q} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, count_q};
		stat.is_free      = (op_q == ffha_pkg::OPC_FREE);
		stat.null_free    = null_q;
		stat.range_bad    = rbad_q;
		stat.clr_done     = (clr_q == GI_W'(GR_DEPTH - 1));
		stat.reinit       = cfg_we && (cfg_index == ffha_pkg::CFG_HEAP_BYTES);
	end

	// memory port selection
	always_comb begin
		ft_we = 1'b0;
		ft_re = 1'b0;
		ft_wa = idx_q[FI_W-1:0];
		ft_ra = idx_q[FI_W-1:0];
		ft_wd = rd_q;
		gr_we = 1'b0;
		gr_re = 1'b0;
		gr_wa = clr_q;
		gr_ra = off_q[GI_W+2:3];
		gr_wd = '0;
		case (cmd.op)
			ffha_pkg::OP_INIT: begin
				ft_we = 1'b1;
				ft_wa = '0;
				ft_wd = '{start: '0, len: usable_c};
			end
			ffha_pkg::OP_CLEAR: gr_we = 1'b1;
			ffha_pkg::OP_FT_READ: ft_re = 1'b1;
			ffha_pkg::OP_GR_READ: gr_re = 1'b1;
			ffha_pkg::OP_SPLIT: begin
				ft_we = 1'b1;
				ft_wd = '{start: rd_q.start + need_q, len: rd_q.len - need_q};
			end
			ffha_pkg::OP_SD_READ: begin
				ft_re = 1'b1;
				ft_ra = k_p1[FI_W-1:0];
			end
			ffha_pkg::OP_SD_WRITE: begin
				ft_we = 1'b1;
				ft_wa = k_q[FI_W-1:0];
			end
			ffha_pkg::OP_MERGE_BOTH: begin
				ft_we = 1'b1;
				ft_wa = idx_m1[FI_W-1:0];
				ft_wd = '{start: prev_q.start, len: prev_q.len + size_f + rd_q.len};
			end
			ffha_pkg::OP_MERGE_PREV: begin
				ft_we = 1'b1;
				ft_wa = idx_m1[FI_W-1:0];
				ft_wd = '{start: prev_q.start, len: prev_q.len + size_f};
			end
			ffha_pkg::OP_MERGE_NEXT: begin
				ft_we = 1'b1;
				ft_wd = '{start: off_q, len: rd_q.len + size_f};
			end
			ffha_pkg::OP_SU_READ: begin
				ft_re = 1'b1;
				ft_ra = k_m1[FI_W-1:0];
			end
			ffha_pkg::OP_SU_WRITE: begin
				ft_we = 1'b1;
				ft_wa = k_q[FI_W-1:0];
			end
			ffha_pkg::OP_INSERT: begin
				ft_we = 1'b1;
				ft_wd = '{start: off_q, len: size_f};
			end
			ffha_pkg::OP_ALLOC_FIN: begin
				gr_we = 1'b1;
				gr_wa = blk_q[GI_W+2:3];
				gr_wd = size_q[OW-1:3];
			end
			ffha_pkg::OP_FREE_FIN: begin
				gr_we = 1'b1;
				gr_wa = off_q[GI_W+2:3];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ft_we) ft_mem[ft_wa] <= ft_wd;
		if (ft_re) rd_q <= ft_mem[ft_ra];
	end

	always_ff @(posedge clk) begin
		if (gr_we) gr_mem[gr_wa] <= gr_wd;
		if (gr_re) grd_q <= gr_mem[gr_ra];
	end

	// configuration and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_hdr_q  <= 32'(HDR);
			hb_q        <= 17'd65536;
			usable_q    <= '0;
			remaining_q <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			clr_q       <= '0;
			op_q        <= ffha_pkg::OPC_ALLOC;
		end else begin
			if (cfg_we && (cfg_index == ffha_pkg::CFG_HEAP_BASE))
				base_hdr_q <= cfg_data + 32'(HDR);
			if (cfg_we && (cfg_index == ffha_pkg::CFG_HEAP_BYTES))
				hb_q <= cfg_data[16:0];
			case (cmd.op)
				ffha_pkg::OP_INIT: begin
					usable_q    <= usable_c;
					remaining_q <= usable_c;
					count_q     <= (usable_c != '0) ? CNT_W'(1) : '0;
					clr_q       <= '0;
				end
				ffha_pkg::OP_CLEAR:     clr_q <= clr_q + GI_W'(1);
				ffha_pkg::OP_CAPTURE: begin
					op_q  <= in_data.op;
					idx_q <= '0;
				end
				ffha_pkg::OP_IDX_INC,
				ffha_pkg::OP_SCAN_NEXT: idx_q <= idx_q + CNT_W'(1);
				ffha_pkg::OP_TAKE,
				ffha_pkg::OP_MERGE_BOTH: k_q <= idx_q;
				ffha_pkg::OP_SD_WRITE:  k_q <= k_p1;
				ffha_pkg::OP_CNT_DEC:   count_q <= count_q - CNT_W'(1);
				ffha_pkg::OP_SU_INIT:   k_q <= count_q;
				ffha_pkg::OP_SU_WRITE:  k_q <= k_m1;
				ffha_pkg::OP_INSERT:    count_q <= count_q + CNT_W'(1);
				ffha_pkg::OP_ALLOC_FIN: remaining_q <= remaining_q - size_q;
				ffha_pkg::OP_FREE_FIN:  remaining_q <= remaining_q + size_f;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ffha_pkg::OP_CAPTURE: begin
				need_q <= need_c;
				off_q  <= off32[OW-1:0];
				null_q <= (in_data.release_address == 32'd0);
				rbad_q <= (off32 >= {15'b0, usable_q}) || (off32[2:0] != 3'd0);
			end
			ffha_pkg::OP_SCAN_NEXT: prev_q <= rd_q;
			ffha_pkg::OP_SPLIT: begin
				size_q <= need_q;
				blk_q  <= rd_q.start;
			end
			ffha_pkg::OP_TAKE: begin
				size_q <= rd_q.len;
				blk_q  <= rd_q.start;
			end
			ffha_pkg::OP_ALLOC_FIN: begin
				out_q.payload_address <= base_hdr_q + {15'b0, blk_q};
				out_q.status          <= ffha_pkg::ST_OK;
				out_q.free_byte_count <= remaining_q - size_q;
			end
			ffha_pkg::OP_FREE_FIN: begin
				out_q.payload_address <= 32'd0;
				out_q.status          <= ffha_pkg::ST_OK;
				out_q.free_byte_count <= remaining_q + size_f;
			end
			ffha_pkg::OP_RESULT: begin
				out_q.payload_address <= 32'd0;
				out_q.status          <= cmd.res;
				out_q.free_byte_count <= remaining_q;
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

	a_remaining_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= usable_q)
		else $error("free byte count exceeds usable heap");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FREE_SLOTS))
		else $error("free table count beyond its slots");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ffha_pkg::OP_INSERT) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not add a free table entry");

	a_split_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == ffha_pkg::OP_SPLIT) |-> (rd_q.len >= need_q))
		else $error("split of a free block that is too small");

endmodule

>>> rtl/core/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator with coalescing free table.
// Allocate scans free entries in order until one fits, then splits it or takes it whole, in which
// case the later entries are shifted down. Free reads the block size, scans for the position,
// then merges with neighbours or inserts a new entry, shifting entries up on insert and down on a
// two-sided merge. One transaction at a time: inputs stall until the sequencer is idle again.
// After reset and after every heap_bytes write the block size memory is cleared,
// one entry a cycle (all min(HEAP_MAX_BYTES/8, 16384) entries), with inputs stalled.
`timescale 1ns / 1ps
module first_fit_heap_allocator_core #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int FREE_SLOTS     = 16,
	parameter int HEADER_BYTES   = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ffha_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ffha_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffha_datapath #(
		.HEAP_MAX_BYTES (HEAP_MAX_BYTES),
		.FREE_SLOTS     (FREE_SLOTS),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

>>> tb/ffha_checker.sv
// Checker for the heap allocator: watches all channels, predicts results, compares them.
`timescale 1ns / 1ps
module ffha_checker #(
	parameter int HEAP_MAX_BYTES = 65536,
	parameter int FREE_SLOTS     = 16,
	parameter int HEADER_BYTES   = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  ffha_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  ffha_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output int                             errors,
	output int                             pending
);

	localparam int unsigned HDR  = ((HEADER_BYTES + 7) / 8) * 8;
	localparam int unsigned GRAN = HEAP_MAX_BYTES / 8;

	int unsigned heap_base_q, heap_size_q, usable_bytes, free_bytes, n_free;
	int unsigned seg_start[FREE_SLOTS];
	int unsigned seg_len[FREE_SLOTS];
	int unsigned blk_gran[GRAN];
	ffha_pkg::out_item_t result_q[$];

	function automatic void rebuild_heap();
		int unsigned eff;
		eff = heap_size_q;
		if (eff > HEAP_MAX_BYTES)
			eff = HEAP_MAX_BYTES;
		eff = eff & ~32'd7;
		if (eff < 64)
			eff = 64;
		usable_bytes = (eff > HDR) ? eff - HDR : 0;
		foreach (seg_start[i]) begin
			seg_start[i] = 0;
			seg_len[i]   = 0;
		end
		foreach (blk_gran[i])
			blk_gran[i] = 0;
		seg_len[0] = usable_bytes;
		n_free     = (usable_bytes != 0) ? 1 : 0;
		free_bytes = usable_bytes;
	endfunction

	function automatic void drop_segment(int unsigned i);
		for (int unsigned k = i; k + 1 < n_free; k++) begin
			seg_start[k] = seg_start[k + 1];
			seg_len[k]   = seg_len[k + 1];
		end
		n_free--;
	endfunction

	function automatic logic [1:0] carve_block(int unsigned req, output logic [31:0] addr);
		int unsigned need, start, len, size;
		need = (req + HDR + 7) & ~32'd7;
		addr = '0;
		for (int unsigned i = 0; i < n_free && i < FREE_SLOTS; i++) begin
			if (seg_len[i] >= need) begin
				start = seg_start[i];
				len   = seg_len[i];
				if (len - need >= HDR + 8) begin
					seg_start[i] = start + need;
					seg_len[i]   = len - need;
					size         = need;
				end else begin
					drop_segment(i);
					size = len;
				end
				blk_gran[(start / 8) % GRAN] = size / 8;
				free_bytes -= size;
				addr = heap_base_q + start + HDR;
				return ffha_pkg::ST_OK;
			end
		end
		return ffha_pkg::ST_NO_SPACE;
	endfunction

	function automatic logic [1:0] release_block(logic [31:0] address);
		int unsigned off, g, size, pos;
		bit join_prev, join_next;
		if (address == 0)
			return ffha_pkg::ST_OK;
		off = address - heap_base_q - HDR;
		if (off >= usable_bytes || (off & 7) != 0)
			return ffha_pkg::ST_BAD_FREE;
		g = off / 8;
		if (g >= GRAN || blk_gran[g] == 0)
			return ffha_pkg::ST_BAD_FREE;
		size = blk_gran[g] * 8;
		pos  = 0;
		while (pos < n_free && seg_start[pos] < off)
			pos++;
		join_prev = pos > 0 && seg_start[pos - 1] + seg_len[pos - 1] == off;
		join_next = pos < n_free && off + size == seg_start[pos];
		if (join_prev && join_next) begin
			seg_len[pos - 1] += size + seg_len[pos];
			drop_segment(pos);
		end else if (join_prev) begin
			seg_len[pos - 1] += size;
		end else if (join_next) begin
			seg_start[pos] = off;
			seg_len[pos]  += size;
		end else begin
			if (n_free >= FREE_SLOTS)
				return ffha_pkg::ST_TABLE_FULL;
			for (int unsigned k = n_free; k > pos; k--) begin
				seg_start[k] = seg_start[k - 1];
				seg_len[k]   = seg_len[k - 1];
			end
			seg_start[pos] = off;
			seg_len[pos]   = size;
			n_free++;
		end
		blk_gran[g] = 0;
		free_bytes += size;
		return ffha_pkg::ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffha_pkg::out_item_t exp_item, got;
		logic [31:0] addr;
		if (!arst_n) begin
			heap_base_q = 0;
			heap_size_q = 65536;
			rebuild_heap();
			result_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
					heap_base_q = cfg_data;
				end else if (cfg_index == ffha_pkg::CFG_HEAP_BYTES) begin
					heap_size_q = cfg_data & 32'h1FFFF;
					rebuild_heap();
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.op == ffha_pkg::OPC_ALLOC) begin
					exp_item.status = carve_block(32'(in_data.request_bytes), addr);
					exp_item.payload_address = addr;
				end else begin
					exp_item.status = release_block(in_data.release_address);
					exp_item.payload_address = '0;
				end
				exp_item.free_byte_count = free_bytes[16:0];
				result_q.push_back(exp_item);
			end
			if (out_valid && !out_stall) begin
				got = out_data;
				if (result_q.size() == 0) begin
					$error("unexpected result transaction: addr %h status %0d free %0d",
						got.payload_address, got.status, got.free_byte_count);
					errors++;
				end else begin
					exp_item = result_q.pop_front();
					if (got.payload_address !== exp_item.payload_address) begin
						$error("payload_address: expected %h, got %h",
							exp_item.payload_address, got.payload_address);
						errors++;
					end
					if (got.status !== exp_item.status) begin
						$error("status: expected %0d, got %0d", exp_item.status, got.status);
						errors++;
					end
					if (got.free_byte_count !== exp_item.free_byte_count) begin
						$error("free_byte_count: expected %0d, got %0d",
							exp_item.free_byte_count, got.free_byte_count);
						errors++;
					end
				end
			end
			pending = result_q.size();
		end
	end

endmodule

>>> tb/tb_first_fit_heap_allocator_core.sv
// Testbench top for the first-fit heap allocator: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_core;

	localparam int IDLE_LIMIT = 40000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	ffha_pkg::in_item_t             in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	ffha_pkg::out_item_t            out_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                    cfg_data = '0;
	int                             errors, pending;

	int          idle_cycles = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [31:0] live_blocks[$];
	logic [31:0] freed_blocks[$];
	logic [31:0] heap_base_now = '0;

	always #5 clk = ~clk;

	first_fit_heap_allocator_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffha_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// receiver stalls: modes of none, light and heavy stalling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// live allocations, used to build well-formed frees
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && out_data.status == ffha_pkg::ST_OK
				&& out_data.payload_address != 0)
			live_blocks.push_back(out_data.payload_address);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_first_fit_heap_allocator_core: FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(logic op, logic [15:0] req, logic [31:0] addr);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data  <= '{op: op, request_bytes: req, release_address: addr};
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	// hold off until all results are back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [ffha_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == ffha_pkg::CFG_HEAP_BASE)
			heap_base_now = value;
		live_blocks.delete();
		freed_blocks.delete();
	endtask

	task automatic random_items(int count);
		int          pick, idx;
		logic [31:0] addr;
		logic [15:0] req;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 - (live_blocks.size() > 40 ? 25 : 0)) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					req = 16'($urandom_range(0, 200));
				else if (pick < 85)
					req = 16'($urandom_range(0, 2000));
				else
					req = 16'($urandom());
				send_item(ffha_pkg::OPC_ALLOC, req, $urandom());
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 75 && live_blocks.size() > 0) begin
					idx  = $urandom_range(0, live_blocks.size() - 1);
					addr = live_blocks[idx];
					live_blocks.delete(idx);
					freed_blocks.push_back(addr);
					if (freed_blocks.size() > 32)
						void'(freed_blocks.pop_front());
				end else if (pick < 85 && freed_blocks.size() > 0) begin
					addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
				end else if (pick < 95) begin
					addr = $urandom();
				end else begin
					addr = '0;
				end
				send_item(ffha_pkg::OPC_FREE, 16'($urandom()), addr);
			end
		end
	endtask

	initial begin
		logic [31:0] b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 1024-byte heap at offset 0
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd1024);
		b = heap_base_now + 24;
		for (int k = 0; k < 6; k++)
			send_item(ffha_pkg::OPC_ALLOC, 16'd0, '0);
		send_item(ffha_pkg::OPC_ALLOC, 16'hFFFF, '0);           // no fit
		send_item(ffha_pkg::OPC_FREE, 16'd0, '0);                // null free
		send_item(ffha_pkg::OPC_FREE, 16'd0, 32'hFFFFFFFF);      // out of range
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 4);             // misaligned
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 24);
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 24);            // double free
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 72);            // insert, no neighbor
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 48);            // merge both sides
		send_item(ffha_pkg::OPC_FREE, 16'd0, b);                 // merge with next
		send_item(ffha_pkg::OPC_ALLOC, 16'd700, '0);             // split tail
		send_item(ffha_pkg::OPC_ALLOC, 16'd96, '0);              // small remainder, whole entry
		send_item(ffha_pkg::OPC_FREE, 16'd0, b + 96);            // merge with previous
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd0);              // clamps up to 64
		send_item(ffha_pkg::OPC_ALLOC, 16'd16, '0);
		send_item(ffha_pkg::OPC_ALLOC, 16'd0, '0);
		send_item(ffha_pkg::OPC_FREE, 16'd0, heap_base_now + 24);

		write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFFFFF8);
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd65536);
		random_items(300);
		drain();                                        // full pause mid-phase
		random_items(100);
		write_reg(ffha_pkg::CFG_HEAP_BASE, {29'($urandom_range(0, 32'h1FFFFFFF)), 3'b000});
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd512);
		random_items(300);
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'h1FFFF);
		random_items(250);
		write_reg(ffha_pkg::CFG_HEAP_BASE, 32'd0);
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd1003);
		random_items(250);
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd64);
		random_items(100);
		write_reg(ffha_pkg::CFG_HEAP_BYTES, 32'd4096);
		random_items(150);
		drain();

		if (errors == 0)
			$display("tb_first_fit_heap_allocator_core: PASS");
		else
			$display("tb_first_fit_heap_allocator_core: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_ctrl.sv
rtl/core/ffha_datapath.sv
rtl/core/first_fit_heap_allocator_core.sv
tb/ffha_checker.sv
tb/tb_first_fit_heap_allocator_core.sv
